/* rtl/core/power_state_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the power-state sequencer
// Shared concurrent assertion forms, clocked on clk; PSS_ASSERT is quiet during rst.
// ----------------------------------------------------------------------------
`ifndef POWER_STATE_SEQUENCER_ASSERT_SVH
`define POWER_STATE_SEQUENCER_ASSERT_SVH

// Checked at every rising edge outside reset.
`define PSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/pss_pkg.sv */
// ----------------------------------------------------------------------------
// Power-state sequencer package
// Types, codes and fixed constants shared by the sequencer files.
// ----------------------------------------------------------------------------
package pss_pkg;

  // Sequencer states, encoded as reported on state_now.
  typedef enum logic [2:0] {
    ST_BOOT   = 3'd0,
    ST_CONN   = 3'd1,
    ST_EXEC   = 3'd2,
    ST_SLEEP  = 3'd3,
    ST_SHUT   = 3'd4,
    ST_RESET  = 3'd5,
    ST_ASLEEP = 3'd6,
    ST_HALT   = 3'd7
  } pss_state_t;

  // Input commands; the unused code is served by default arms.
  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_WAKE_REQ = 3'd1,
    CMD_PUBLISH  = 3'd2,
    CMD_RESET    = 3'd3,
    CMD_SHUTDOWN = 3'd4,
    CMD_VITALS   = 3'd5,
    CMD_WOKE     = 3'd6
  } pss_cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_PAST      = 3'd1,
    STS_SKIPPED   = 3'd2,
    STS_CANCELLED = 3'd3,
    STS_IGNORED   = 3'd4
  } pss_status_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SLEEP_ENABLE     = 3'd0,
    CFG_EXEC_MIN_SEC     = 3'd1,
    CFG_CONNECT_MAX_SEC  = 3'd2,
    CFG_SHUTDOWN_TIMEOUT = 3'd3,
    CFG_RESET_TIMEOUT    = 3'd4
  } pss_cfg_idx_t;

  localparam int TIME_WIDTH   = 40;
  localparam int SEC_WIDTH    = 17;
  localparam int SEC_MS_WIDTH = SEC_WIDTH + 10;
  localparam int DUR_WIDTH    = 32;

  localparam logic [SEC_MS_WIDTH-1:0] MS_PER_SEC   = SEC_MS_WIDTH'(1000);
  localparam logic [DUR_WIDTH-1:0]    MIN_SLEEP_MS = DUR_WIDTH'(1000);

  // Register values after reset.
  localparam logic [SEC_MS_WIDTH-1:0] EXEC_MIN_MS_RESET    = SEC_MS_WIDTH'(10000);
  localparam logic [SEC_MS_WIDTH-1:0] CONNECT_MAX_MS_RESET = SEC_MS_WIDTH'(90000);
  localparam logic [DUR_WIDTH-1:0]    SHUTDOWN_TIMEOUT_RESET = DUR_WIDTH'(60000);
  localparam logic [DUR_WIDTH-1:0]    RESET_TIMEOUT_RESET    = DUR_WIDTH'(60000);

  typedef struct packed {
    logic [2:0]            cmd;
    logic [TIME_WIDTH-1:0] now_ms;
    logic [TIME_WIDTH-1:0] wake_ms;
    logic                  connected;
    logic                  hold_sleep;
    logic                  full_wakeup;
  } pss_item_t;

  typedef struct packed {
    logic [2:0]           state_now;
    logic [2:0]           status;
    logic                 publish_vitals;
    logic                 modem_start;
    logic                 modem_stop;
    logic                 trigger_location;
    logic                 sleep_now;
    logic [DUR_WIDTH-1:0] sleep_duration_ms;
    logic                 enter_shipping;
    logic                 start_reset;
  } pss_result_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } pss_cfg_t;

endpackage

/* rtl/core/pss_chan_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready channel
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface pss_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/core/power_state_sequencer.sv */
// ----------------------------------------------------------------------------
// Power-state sequencer
// Steps a device through boot, connecting, execute, sleep, asleep, shutdown,
// reset and halted. The item channel carries ticks with the current time,
// wake-time requests, event flags and wake notices. Each item transaction
// yields exactly one result transaction on the result channel, holding the
// new state, a status code and one-transaction action pulses.
// The cfg channel writes the five registers by index; it is always ready. The
// user must write it only while no item is in flight; the block does not enforce this.
// Each result is registered, in the result register or, while an earlier
// result waits, in the skid register. Throughput is one item per cycle while
// item.ready is high, in a single pass from the item port into the state and result registers.
// A result register and a skid register sit on the result side; a new item
// is taken while a result waits, and item.ready drops only once both hold a
// result that the receiver has not taken.
// Synchronous reset returns the state to boot, clears all stored times and
// flags, and loads the register defaults.
// ----------------------------------------------------------------------------
`include "power_state_sequencer_assert.svh"

module power_state_sequencer (
  input  logic              clk,
  input  logic              rst,
  pss_chan_if.sink          item,
  pss_chan_if.source        result,
  pss_chan_if.sink          cfg
);

  import pss_pkg::*;

  // Configuration registers, second values kept in milliseconds.
  logic                    sleep_enable;
  logic [SEC_MS_WIDTH-1:0] exec_min_ms;
  logic [SEC_MS_WIDTH-1:0] connect_max_ms;
  logic [DUR_WIDTH-1:0]    shutdown_timeout_ms;
  logic [DUR_WIDTH-1:0]    reset_timeout_ms;

  // Sequencer state.
  pss_state_t            state, state_next;
  logic [TIME_WIDTH-1:0] next_wake, next_wake_next;
  logic [TIME_WIDTH-1:0] connect_start, connect_start_next;
  logic [TIME_WIDTH-1:0] execute_start, execute_start_next;
  logic [TIME_WIDTH-1:0] halt_start, halt_start_next;
  logic                  publish_seen, publish_seen_next;
  logic                  reset_pending, reset_pending_next;
  logic                  shutdown_pending, shutdown_pending_next;
  logic                  vitals_pending, vitals_pending_next;
  logic                  wakeup_override, wakeup_override_next;
  logic                  modem_full_on, modem_full_on_next;

  // Output stage.
  logic        out_valid;
  pss_result_t out_data;
  logic        skid_valid;
  pss_result_t skid_data;

  // Single-pass work signals.
  pss_item_t             in_data;
  pss_result_t           res;
  logic                  item_fire;
  logic                  out_take;
  logic [TIME_WIDTH-1:0] el_conn;
  logic [TIME_WIDTH-1:0] el_exec;
  logic [TIME_WIDTH-1:0] el_halt;
  logic [TIME_WIDTH-1:0] sleep_diff;
  logic [DUR_WIDTH-1:0]  sleep_dur;
  logic                  ovr;

  assign in_data   = item.data;
  assign item_fire = item.valid && item.ready;
  assign out_take  = out_valid && result.ready;

  assign item.ready   = !skid_valid;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Elapsed times wrap modulo the 40-bit time width.
  assign el_conn    = in_data.now_ms - connect_start;
  assign el_exec    = in_data.now_ms - execute_start;
  assign el_halt    = in_data.now_ms - halt_start;
  assign sleep_diff = next_wake - in_data.now_ms;

  // Sleep length: saturated to 32 bits, with a floor when the wake time is now.
  always_comb begin
    if (sleep_diff == '0) begin
      sleep_dur = MIN_SLEEP_MS;
    end else if (|sleep_diff[TIME_WIDTH-1:DUR_WIDTH]) begin
      sleep_dur = '1;
    end else begin
      sleep_dur = sleep_diff[DUR_WIDTH-1:0];
    end
  end

  // Next state and result for the item on the input port.
  always_comb begin
    state_next            = state;
    next_wake_next        = next_wake;
    connect_start_next    = connect_start;
    execute_start_next    = execute_start;
    halt_start_next       = halt_start;
    publish_seen_next     = publish_seen;
    reset_pending_next    = reset_pending;
    shutdown_pending_next = shutdown_pending;
    vitals_pending_next   = vitals_pending;
    wakeup_override_next  = wakeup_override;
    modem_full_on_next    = modem_full_on;
    res                   = '0;
    ovr                   = wakeup_override;

    if (state == ST_HALT && in_data.cmd != CMD_TICK) begin
      res.status = STS_IGNORED;
    end else begin
      case (in_data.cmd)
        CMD_TICK: begin
          case (state)
            ST_BOOT: begin
              wakeup_override_next = 1'b0;
              state_next           = ST_CONN;
              connect_start_next   = in_data.now_ms;
              publish_seen_next    = 1'b0;
              res.modem_start      = 1'b1;
              modem_full_on_next   = 1'b1;
            end
            ST_CONN: begin
              if (vitals_pending && in_data.connected) begin
                vitals_pending_next = 1'b0;
                res.publish_vitals  = 1'b1;
              end
              if (publish_seen && in_data.connected) begin
                publish_seen_next  = 1'b0;
                state_next         = ST_EXEC;
                execute_start_next = in_data.now_ms;
              end else if (el_conn >= TIME_WIDTH'(connect_max_ms)) begin
                res.trigger_location = 1'b1;
                state_next           = ST_EXEC;
                execute_start_next   = in_data.now_ms;
              end
            end
            ST_EXEC: begin
              if (sleep_enable) begin
                if (!modem_full_on && (vitals_pending || shutdown_pending)) begin
                  ovr = 1'b1;
                end
                wakeup_override_next = ovr;
                if (!modem_full_on && ovr) begin
                  wakeup_override_next = 1'b0;
                  state_next           = ST_CONN;
                  connect_start_next   = in_data.now_ms;
                  publish_seen_next    = 1'b0;
                  res.modem_start      = 1'b1;
                  modem_full_on_next   = 1'b1;
                end else begin
                  if (shutdown_pending) begin
                    state_next      = ST_SHUT;
                    halt_start_next = in_data.now_ms;
                  end else if (reset_pending) begin
                    state_next      = ST_RESET;
                    halt_start_next = in_data.now_ms;
                  end
                  if (!in_data.hold_sleep && el_exec >= TIME_WIDTH'(exec_min_ms)) begin
                    state_next = ST_SLEEP;
                  end
                end
              end else begin
                execute_start_next = in_data.now_ms;
                if (vitals_pending && in_data.connected) begin
                  vitals_pending_next = 1'b0;
                  res.publish_vitals  = 1'b1;
                end
                if (shutdown_pending) begin
                  state_next      = ST_SHUT;
                  halt_start_next = in_data.now_ms;
                end else if (reset_pending) begin
                  state_next      = ST_RESET;
                  halt_start_next = in_data.now_ms;
                end
              end
            end
            ST_SLEEP: begin
              wakeup_override_next = 1'b0;
              if (next_wake == '0 || next_wake < in_data.now_ms) begin
                next_wake_next     = '0;
                res.status         = STS_CANCELLED;
                state_next         = ST_EXEC;
                execute_start_next = in_data.now_ms;
              end else begin
                res.modem_stop        = 1'b1;
                modem_full_on_next    = 1'b0;
                res.sleep_now         = 1'b1;
                res.sleep_duration_ms = sleep_dur;
                state_next            = ST_ASLEEP;
              end
            end
            ST_SHUT: begin
              if (vitals_pending && in_data.connected) begin
                vitals_pending_next = 1'b0;
                res.publish_vitals  = 1'b1;
              end
              if ((publish_seen && in_data.connected) ||
                  el_halt >= TIME_WIDTH'(shutdown_timeout_ms)) begin
                res.modem_stop     = 1'b1;
                modem_full_on_next = 1'b0;
                res.enter_shipping = 1'b1;
                state_next         = ST_HALT;
              end
            end
            ST_RESET: begin
              if (vitals_pending && in_data.connected) begin
                vitals_pending_next = 1'b0;
                res.publish_vitals  = 1'b1;
              end
              if ((publish_seen && in_data.connected) ||
                  el_halt >= TIME_WIDTH'(reset_timeout_ms)) begin
                res.start_reset = 1'b1;
                state_next      = ST_HALT;
              end
            end
            ST_ASLEEP: begin
              res.status = STS_IGNORED;
            end
            default: begin
              // Halted: a tick does nothing.
            end
          endcase
        end
        CMD_WAKE_REQ: begin
          if (in_data.wake_ms == '0) begin
            next_wake_next = '0;
          end else if (in_data.wake_ms <= in_data.now_ms) begin
            res.status = STS_PAST;
          end else if (next_wake != '0 && in_data.wake_ms > next_wake) begin
            res.status = STS_SKIPPED;
          end else begin
            next_wake_next = in_data.wake_ms;
          end
        end
        CMD_PUBLISH:  publish_seen_next     = 1'b1;
        CMD_RESET:    reset_pending_next    = 1'b1;
        CMD_SHUTDOWN: shutdown_pending_next = 1'b1;
        CMD_VITALS:   vitals_pending_next   = 1'b1;
        CMD_WOKE: begin
          if (state != ST_ASLEEP) begin
            res.status = STS_IGNORED;
          end else begin
            next_wake_next = '0;
            if (in_data.full_wakeup) begin
              wakeup_override_next = 1'b0;
              state_next           = ST_CONN;
              connect_start_next   = in_data.now_ms;
              publish_seen_next    = 1'b0;
              res.modem_start      = 1'b1;
              modem_full_on_next   = 1'b1;
            end else begin
              wakeup_override_next = 1'b0;
              modem_full_on_next   = 1'b0;
              state_next           = ST_EXEC;
              execute_start_next   = in_data.now_ms;
            end
          end
        end
        default: begin
          res.status = STS_IGNORED;
        end
      endcase
    end

    res.state_now = state_next;
  end

  // Configuration writes; second values are scaled to milliseconds here.
  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_enable        <= 1'b0;
      exec_min_ms         <= EXEC_MIN_MS_RESET;
      connect_max_ms      <= CONNECT_MAX_MS_RESET;
      shutdown_timeout_ms <= SHUTDOWN_TIMEOUT_RESET;
      reset_timeout_ms    <= RESET_TIMEOUT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.data.index)
        CFG_SLEEP_ENABLE:     sleep_enable <= cfg.data.value[0];
        CFG_EXEC_MIN_SEC:
          exec_min_ms <= SEC_MS_WIDTH'(cfg.data.value[SEC_WIDTH-1:0]) * MS_PER_SEC;
        CFG_CONNECT_MAX_SEC:
          connect_max_ms <= SEC_MS_WIDTH'(cfg.data.value[SEC_WIDTH-1:0]) * MS_PER_SEC;
        CFG_SHUTDOWN_TIMEOUT: shutdown_timeout_ms <= cfg.data.value;
        CFG_RESET_TIMEOUT:    reset_timeout_ms    <= cfg.data.value;
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // State register, updated once per item transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_BOOT;
      next_wake        <= '0;
      connect_start    <= '0;
      execute_start    <= '0;
      halt_start       <= '0;
      publish_seen     <= 1'b0;
      reset_pending    <= 1'b0;
      shutdown_pending <= 1'b0;
      vitals_pending   <= 1'b0;
      wakeup_override  <= 1'b0;
      modem_full_on    <= 1'b0;
    end else if (item_fire) begin
      state            <= state_next;
      next_wake        <= next_wake_next;
      connect_start    <= connect_start_next;
      execute_start    <= execute_start_next;
      halt_start       <= halt_start_next;
      publish_seen     <= publish_seen_next;
      reset_pending    <= reset_pending_next;
      shutdown_pending <= shutdown_pending_next;
      vitals_pending   <= vitals_pending_next;
      wakeup_override  <= wakeup_override_next;
      modem_full_on    <= modem_full_on_next;
    end
  end

  // Result and skid valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!item_fire) begin
        out_valid <= 1'b0;
      end
    end else if (item_fire) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  // Result and skid payloads.
  always_ff @(posedge clk) begin
    if (out_take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (item_fire) begin
        out_data <= res;
      end
    end else if (item_fire) begin
      if (out_valid) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  // The skid register only fills behind a waiting result.
  `PSS_ASSERT(a_skid_behind_out, skid_valid |-> out_valid, "skid holds data with no result")
  // Halted is a final state.
  `PSS_ASSERT(a_halt_final, state == ST_HALT |=> state == ST_HALT, "left the halted state")
  // A sleep pulse always moves to asleep with a nonzero length.
  `PSS_ASSERT(a_sleep_result,
    out_valid && out_data.sleep_now |-> out_data.state_now == ST_ASLEEP && out_data.sleep_duration_ms != '0,
    "sleep pulse without asleep state or length")
  // Shipping and reset pulses only come with the halted state.
  `PSS_ASSERT(a_halt_pulses,
    out_valid && (out_data.enter_shipping || out_data.start_reset) |-> out_data.state_now == ST_HALT,
    "shipping or reset pulse outside halted")
  // Nothing leaves the block during reset.
  `PSS_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid && !skid_valid, "result valid after reset")

endmodule

/* sim/pss_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-state sequencer scoreboard
// Holds an independent model of the sequencer, its registers and its state.
// Each accepted item transaction is run through the model, and the expected
// result is queued. Each result transaction is checked field by field
// against the oldest queued result.
// ----------------------------------------------------------------------------
package pss_tb_pkg;

  import pss_pkg::*;

  // Command code that the block does not define.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  class sequencer_scoreboard;

    // Register copies.
    logic        sleep_en;
    logic [16:0] exec_min_s;
    logic [16:0] conn_max_s;
    logic [31:0] shut_to_ms;
    logic [31:0] reset_to_ms;

    // Model state.
    pss_state_t  cur_state;
    logic [39:0] next_wake;
    logic [39:0] connect_start;
    logic [39:0] execute_start;
    logic [39:0] halt_start;
    bit          publish_seen;
    bit          reset_pend;
    bit          shutdown_pend;
    bit          vitals_pend;
    bit          wake_override;
    bit          modem_on;

    pss_result_t pending_results[$];
    int          errors;

    function new();
      sleep_en      = 1'b0;
      exec_min_s    = 17'd10;
      conn_max_s    = 17'd90;
      shut_to_ms    = 32'd60000;
      reset_to_ms   = 32'd60000;
      cur_state     = ST_BOOT;
      next_wake     = '0;
      connect_start = '0;
      execute_start = '0;
      halt_start    = '0;
      publish_seen  = 1'b0;
      reset_pend    = 1'b0;
      shutdown_pend = 1'b0;
      vitals_pend   = 1'b0;
      wake_override = 1'b0;
      modem_on      = 1'b0;
      errors        = 0;
    endfunction

    // A register write; values wider than the register are truncated.
    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        CFG_SLEEP_ENABLE:     sleep_en    = value[0];
        CFG_EXEC_MIN_SEC:     exec_min_s  = value[16:0];
        CFG_CONNECT_MAX_SEC:  conn_max_s  = value[16:0];
        CFG_SHUTDOWN_TIMEOUT: shut_to_ms  = value;
        CFG_RESET_TIMEOUT:    reset_to_ms = value;
        default: ;
      endcase
    endfunction

    // Elapsed time wraps at 40 bits, so a clock stepping back reads as long.
    function bit timed_out(logic [39:0] now, logic [39:0] start, logic [63:0] limit_ms);
      logic [39:0] span;
      span = now - start;
      return {24'd0, span} >= limit_ms;
    endfunction

    function void start_connect(logic [39:0] now, inout pss_result_t r);
      wake_override  = 1'b0;
      cur_state      = ST_CONN;
      connect_start  = now;
      publish_seen   = 1'b0;
      r.modem_start  = 1'b1;
      modem_on       = 1'b1;
    endfunction

    function void start_execute(logic [39:0] now);
      cur_state     = ST_EXEC;
      execute_start = now;
    endfunction

    function void start_halt_wait(pss_state_t st, logic [39:0] now);
      cur_state  = st;
      halt_start = now;
    endfunction

    function void flush_vitals(bit conn, inout pss_result_t r);
      if (vitals_pend && conn) begin
        vitals_pend      = 1'b0;
        r.publish_vitals = 1'b1;
      end
    endfunction

    // One tick of the state machine.
    function void advance_tick(logic [39:0] now, bit conn, bit hold, inout pss_result_t r);
      logic [39:0] span;
      case (cur_state)
        ST_BOOT: begin
          start_connect(now, r);
        end
        ST_CONN: begin
          flush_vitals(conn, r);
          if (publish_seen && conn) begin
            publish_seen = 1'b0;
            start_execute(now);
          end else if (timed_out(now, connect_start, 64'(conn_max_s) * 64'd1000)) begin
            r.trigger_location = 1'b1;
            start_execute(now);
          end
        end
        ST_EXEC: begin
          if (sleep_en) begin
            if (!modem_on && (vitals_pend || shutdown_pend))
              wake_override = 1'b1;
            if (!modem_on && wake_override) begin
              start_connect(now, r);
            end else begin
              if (shutdown_pend)
                start_halt_wait(ST_SHUT, now);
              else if (reset_pend)
                start_halt_wait(ST_RESET, now);
              // Sleep wins even over a halt wait entered on this same tick.
              if (!hold && timed_out(now, execute_start, 64'(exec_min_s) * 64'd1000))
                cur_state = ST_SLEEP;
            end
          end else begin
            execute_start = now;
            flush_vitals(conn, r);
            if (shutdown_pend)
              start_halt_wait(ST_SHUT, now);
            else if (reset_pend)
              start_halt_wait(ST_RESET, now);
          end
        end
        ST_SLEEP: begin
          wake_override = 1'b0;
          if (next_wake == '0 || next_wake < now) begin
            next_wake = '0;
            r.status  = STS_CANCELLED;
            start_execute(now);
          end else begin
            span = next_wake - now;
            if (span == '0)
              r.sleep_duration_ms = MIN_SLEEP_MS;
            else if (span > 40'hFF_FFFF_FFFF >> 8)
              r.sleep_duration_ms = '1;
            else
              r.sleep_duration_ms = span[31:0];
            r.modem_stop = 1'b1;
            modem_on     = 1'b0;
            r.sleep_now  = 1'b1;
            cur_state    = ST_ASLEEP;
          end
        end
        ST_SHUT: begin
          flush_vitals(conn, r);
          if ((publish_seen && conn) || timed_out(now, halt_start, 64'(shut_to_ms))) begin
            r.modem_stop     = 1'b1;
            modem_on         = 1'b0;
            r.enter_shipping = 1'b1;
            cur_state        = ST_HALT;
          end
        end
        ST_RESET: begin
          flush_vitals(conn, r);
          if ((publish_seen && conn) || timed_out(now, halt_start, 64'(reset_to_ms))) begin
            r.start_reset = 1'b1;
            cur_state     = ST_HALT;
          end
        end
        ST_ASLEEP: begin
          r.status = STS_IGNORED;
        end
        default: ;
      endcase
    endfunction

    // Runs an accepted item through the model and queues its result.
    function void note_item(pss_item_t it);
      pss_result_t r;
      r = '0;
      if (cur_state == ST_HALT && it.cmd != CMD_TICK) begin
        r.status = STS_IGNORED;
      end else begin
        case (it.cmd)
          CMD_TICK: begin
            advance_tick(it.now_ms, it.connected, it.hold_sleep, r);
          end
          CMD_WAKE_REQ: begin
            if (it.wake_ms == '0)
              next_wake = '0;
            else if (it.wake_ms <= it.now_ms)
              r.status = STS_PAST;
            else if (next_wake != '0 && it.wake_ms > next_wake)
              r.status = STS_SKIPPED;
            else
              next_wake = it.wake_ms;
          end
          CMD_PUBLISH:  publish_seen  = 1'b1;
          CMD_RESET:    reset_pend    = 1'b1;
          CMD_SHUTDOWN: shutdown_pend = 1'b1;
          CMD_VITALS:   vitals_pend   = 1'b1;
          CMD_WOKE: begin
            if (cur_state != ST_ASLEEP) begin
              r.status = STS_IGNORED;
            end else begin
              next_wake     = '0;
              modem_on      = 1'b0;
              wake_override = it.full_wakeup;
              if (wake_override)
                start_connect(it.now_ms, r);
              else
                start_execute(it.now_ms);
            end
          end
          default: r.status = STS_IGNORED;
        endcase
      end
      r.state_now = cur_state;
      pending_results.push_back(r);
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Checks one result transaction against the oldest queued result.
    function void check_result(pss_result_t got);
      pss_result_t want;
      bit          ok;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item outstanding, expected none, actual state %0d",
                 $time, got.state_now);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      ok = 1'b1;
      ok &= field_ok("state_now", 32'(want.state_now), 32'(got.state_now));
      ok &= field_ok("status", 32'(want.status), 32'(got.status));
      ok &= field_ok("publish_vitals", 32'(want.publish_vitals), 32'(got.publish_vitals));
      ok &= field_ok("modem_start", 32'(want.modem_start), 32'(got.modem_start));
      ok &= field_ok("modem_stop", 32'(want.modem_stop), 32'(got.modem_stop));
      ok &= field_ok("trigger_location", 32'(want.trigger_location),
                     32'(got.trigger_location));
      ok &= field_ok("sleep_now", 32'(want.sleep_now), 32'(got.sleep_now));
      ok &= field_ok("sleep_duration_ms", want.sleep_duration_ms, got.sleep_duration_ms);
      ok &= field_ok("enter_shipping", 32'(want.enter_shipping), 32'(got.enter_shipping));
      ok &= field_ok("start_reset", 32'(want.start_reset), 32'(got.start_reset));
      if (!ok)
        errors++;
    endfunction

  endclass

endpackage

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-state sequencer testbench
// Drives directed and random item streams through the sequencer under several
// register settings and idling patterns, and checks every result transaction
// against the scoreboard model. The run ends by steering the block through a
// halt wait into the halted state.
// ----------------------------------------------------------------------------
module tb_top;

  import pss_pkg::*;
  import pss_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 145;

  logic clk;
  logic rst;

  pss_chan_if #(.payload_t(pss_item_t))   item_ch ();
  pss_chan_if #(.payload_t(pss_result_t)) result_ch ();
  pss_chan_if #(.payload_t(pss_cfg_t))    cfg_ch ();

  power_state_sequencer u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  sequencer_scoreboard sb;
  int                  send_idle_pct;
  int                  stall_pct;
  int                  cycles = 0;
  logic [39:0]         clock_ms;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checking.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.data);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** power_state_sequencer: FAILED **");
      $finish;
    end
  end

  function automatic logic [39:0] rand40();
    return {8'($urandom_range(255)), 32'($urandom)};
  endfunction

  function automatic pss_item_t mk(logic [2:0] cmd, logic [39:0] now, logic [39:0] wake,
                                   bit conn, bit hold, bit full);
    pss_item_t it;
    it.cmd         = cmd;
    it.now_ms      = now;
    it.wake_ms     = wake;
    it.connected   = conn;
    it.hold_sleep  = hold;
    it.full_wakeup = full;
    return it;
  endfunction

  // Random item, steered by the model state so that most streams stay well formed.
  function automatic pss_item_t random_item();
    pss_item_t it;
    int        r;
    it.wake_ms     = rand40();
    it.connected   = ($urandom_range(99) < 75);
    it.hold_sleep  = ($urandom_range(99) < 20);
    it.full_wakeup = 1'($urandom_range(1));

    // Time mostly moves forward in small steps, with rare jumps and wraps.
    r = $urandom_range(99);
    if (r < 70)
      clock_ms += 40'($urandom_range(2000));
    else if (r < 90)
      clock_ms += 40'($urandom_range(20000));
    else if (r < 97)
      clock_ms += 40'($urandom_range(200000));
    else if (r < 99)
      clock_ms = rand40();
    else
      clock_ms = 40'hFF_FFFF_FFFF - 40'($urandom_range(5000));

    if (sb.cur_state == ST_ASLEEP && $urandom_range(99) < 65) begin
      it.cmd = CMD_WOKE;
    end else begin
      r = $urandom_range(99);
      if (r < 58)      it.cmd = CMD_TICK;
      else if (r < 72) it.cmd = CMD_WAKE_REQ;
      else if (r < 80) it.cmd = CMD_PUBLISH;
      else if (r < 88) it.cmd = CMD_VITALS;
      else if (r < 96) it.cmd = CMD_WOKE;
      else             it.cmd = CMD_UNUSED;
    end

    // Let some sleep entries land exactly on the wake time.
    if (it.cmd == CMD_TICK && sb.cur_state == ST_SLEEP && sb.next_wake != '0
        && $urandom_range(99) < 20)
      clock_ms = sb.next_wake;

    if (it.cmd == CMD_WAKE_REQ) begin
      r = $urandom_range(99);
      if (r < 10)      it.wake_ms = '0;
      else if (r < 20) it.wake_ms = clock_ms - 40'($urandom_range(1000));
      else if (r < 30) it.wake_ms = rand40();
      else if (r < 35) it.wake_ms = clock_ms + (40'd1 << 33) + 40'($urandom);
      else             it.wake_ms = clock_ms + 40'($urandom_range(30000, 1));
    end
    it.now_ms = clock_ms;
    return it;
  endfunction

  // Offers one item, with random idle cycles before it, and waits for acceptance.
  task automatic send(input pss_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(it);
  endtask

  // Holds off the sender until every queued result has arrived.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input pss_cfg_idx_t idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= pss_cfg_t'{index: idx, value: value};
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, value);
  endtask

  task automatic program_regs(input logic sleep_on, input logic [31:0] exec_s,
                              input logic [31:0] conn_s, input logic [31:0] shut_ms,
                              input logic [31:0] reset_ms);
    drain();
    write_reg(CFG_SLEEP_ENABLE, {31'd0, sleep_on});
    write_reg(CFG_EXEC_MIN_SEC, exec_s);
    write_reg(CFG_CONNECT_MAX_SEC, conn_s);
    write_reg(CFG_SHUTDOWN_TIMEOUT, shut_ms);
    write_reg(CFG_RESET_TIMEOUT, reset_ms);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 73; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 73; end
      default: begin send_idle_pct = 20; stall_pct = 20; end
    endcase
  endtask

  // Moves the block one step toward execute with the modem on.
  task automatic steer_step();
    clock_ms += 40'd500;
    if (sb.cur_state == ST_ASLEEP)
      send(mk(CMD_WOKE, clock_ms, '0, 1'b1, 1'b1, 1'($urandom_range(1))));
    else
      send(mk(CMD_TICK, clock_ms, '0, 1'b1, 1'b1, 1'b0));
  endtask

  // Issues the halting requests and follows the block into halted.
  task automatic run_to_halt();
    pss_item_t it;
    while (!(sb.cur_state == ST_EXEC && sb.modem_on)) begin
      if (sb.cur_state == ST_EXEC)
        send(mk(CMD_VITALS, clock_ms, '0, 1'b1, 1'b0, 1'b0));
      steer_step();
    end

    // The reset wait and the end of execute fall on the same tick.
    send(mk(CMD_RESET, clock_ms, '0, 1'b1, 1'b0, 1'b0));
    clock_ms += 40'd1000;
    send(mk(CMD_TICK, clock_ms, '0, 1'b1, 1'b0, 1'b0));

    // Either stay on the reset path or let a shutdown take over.
    if ($urandom_range(1))
      send(mk(CMD_SHUTDOWN, clock_ms, '0, 1'b1, 1'b0, 1'b0));
    while (sb.cur_state != ST_SHUT && sb.cur_state != ST_RESET && sb.cur_state != ST_HALT)
      steer_step();

    while (sb.cur_state != ST_HALT) begin
      clock_ms += 40'($urandom_range(4000));
      if ($urandom_range(99) < 5)
        send(mk(CMD_PUBLISH, clock_ms, rand40(), 1'b1, 1'b0, 1'b0));
      else
        send(mk(CMD_TICK, clock_ms, rand40(), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'b0));
    end

    // Everything but a tick is refused once halted.
    repeat (30) begin
      it = random_item();
      it.cmd = 3'($urandom_range(7));
      send(it);
    end
  endtask

  // Main sequence.
  initial begin
    logic        sl;
    logic [31:0] ex;
    logic [31:0] cn;
    logic [31:0] sh;
    logic [31:0] rs;

    sb = new();
    clock_ms = '0;
    set_idling(0);
    rst             <= 1'b1;
    item_ch.valid   <= 1'b0;
    item_ch.data    <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: connect, vitals, publish and wake requests at register defaults.
    send(mk(CMD_TICK, 40'd0, 40'd0, 1'b0, 1'b0, 1'b0));
    send(mk(CMD_UNUSED, 40'd500, 40'd0, 1'b0, 1'b0, 1'b0));
    send(mk(CMD_WOKE, 40'd600, 40'd0, 1'b0, 1'b0, 1'b1));
    send(mk(CMD_VITALS, 40'd700, 40'd0, 1'b0, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'd1000, 40'd0, 1'b0, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'd2000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_PUBLISH, 40'd2500, 40'd0, 1'b0, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'd3000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_WAKE_REQ, 40'd3500, 40'd0, 1'b0, 1'b0, 1'b0));
    send(mk(CMD_WAKE_REQ, 40'd4000, 40'd4000, 1'b0, 1'b0, 1'b0));
    send(mk(CMD_WAKE_REQ, 40'd5000, 40'd50000, 1'b0, 1'b0, 1'b0));
    send(mk(CMD_WAKE_REQ, 40'hFF_FFFF_FFFE, 40'hFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1));

    // Directed: sleep at the wake time, cancel, override wake and saturation.
    program_regs(1'b1, 32'd0, 32'd90, 32'd60000, 32'd60000);
    send(mk(CMD_TICK, 40'd20000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'd50000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'd51000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_WOKE, 40'd52000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'd53000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'd54000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_WAKE_REQ, 40'd54500, 40'd54500 + (40'd1 << 34), 1'b0, 1'b0, 1'b0));
    send(mk(CMD_VITALS, 40'd54600, 40'd0, 1'b0, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'd55000, 40'd0, 1'b0, 1'b1, 1'b0));
    send(mk(CMD_TICK, 40'd56000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_PUBLISH, 40'd56500, 40'd0, 1'b0, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'd57000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'd58000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_TICK, 40'd59000, 40'd0, 1'b1, 1'b0, 1'b0));
    send(mk(CMD_WOKE, 40'd60000, 40'd0, 1'b1, 1'b0, 1'b1));
    clock_ms = 40'd60000;

    // Random phases, each under its own register setting and idling pattern.
    for (int k = 0; k < 7; k++) begin
      sl = 1'b1;
      sh = $urandom;
      rs = $urandom;
      case (k)
        0: begin ex = 32'd0; cn = 32'd0; sh = 32'd0; rs = 32'd0; end
        1: begin ex = $urandom_range(5); cn = $urandom_range(10); end
        2: begin
          sl = 1'b0; ex = 32'd86400; cn = 32'd86400; sh = '1; rs = '1;
        end
        3: begin ex = 32'd1; cn = 32'd2; end
        4: begin ex = $urandom_range(20); cn = $urandom_range(60); end
        5: begin
          sl = 1'($urandom_range(1)); ex = $urandom_range(86400);
          cn = $urandom_range(86400);
        end
        default: begin ex = $urandom_range(3); cn = $urandom_range(5); end
      endcase
      program_regs(sl, ex, cn, sh, rs);
      set_idling(k % 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (k == 1 && i == 70)
          drain();
        send(random_item());
      end
    end

    // Closing phase: a halt wait ends in halted.
    program_regs(1'b1, 32'd0, 32'd0, $urandom_range(30000), $urandom_range(30000));
    set_idling(3);
    run_to_halt();

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("** power_state_sequencer: PASSED **");
    else
      $display("** power_state_sequencer: FAILED **");
    $finish;
  end

endmodule

/* power_state_sequencer.f */
+incdir+rtl/core
rtl/core/pss_pkg.sv
rtl/core/pss_chan_if.sv
rtl/core/power_state_sequencer.sv
sim/pss_tb_pkg.sv
sim/tb_top.sv
